// ----- rtl/pixel_tone_map_colormap_assert.svh -----
`ifndef PIXEL_TONE_MAP_COLORMAP_ASSERT_SVH
`define PIXEL_TONE_MAP_COLORMAP_ASSERT_SVH

// Same-cycle check, sampled on clk, off while rst is high.
`define PTMC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle check, sampled on clk, off while rst is high.
`define PTMC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ptmc_pkg.sv -----
package ptmc_pkg;

  localparam int PIXEL_BITS     = 16;
  localparam int NORM_FRAC_BITS = 12;

  localparam int PIX_W     = 16;
  localparam int CH_W      = 8;
  localparam int CFG_W     = 18;
  localparam int CFG_IDX_W = 3;
  localparam int GAMMA_W   = 12;
  localparam int CMAP_W    = 2;

  localparam int NUM_W = CFG_W + 1;
  localparam int DEN_W = CFG_W;
  localparam int T_W   = NORM_FRAC_BITS + 1;

  localparam logic [T_W-1:0] ONE_T = {1'b1, {NORM_FRAC_BITS{1'b0}}};

  // log2 in fixed point: integer part from the leading one, 16 fraction bits
  localparam int LOG_FRAC_W = 16;
  localparam int LOG_INT_W  = $clog2(NORM_FRAC_BITS + 1);
  localparam int LOG_W      = LOG_INT_W + LOG_FRAC_W;
  localparam logic [LOG_W-1:0] LOG_TOP =
    {LOG_INT_W'(NORM_FRAC_BITS), {LOG_FRAC_W{1'b0}}};

  localparam int MANT_W   = 32;
  localparam int MANT_TOP = 30;

  localparam int GAMMA_SHIFT = 8;
  localparam int DT_W        = LOG_W + GAMMA_SHIFT;
  localparam logic [GAMMA_W-1:0] GAMMA_UNITY = GAMMA_W'(1 << GAMMA_SHIFT);

  localparam logic [CFG_IDX_W-1:0] CFG_WIN_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAMMA    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CMAP     = 3'd4;

  localparam logic [CMAP_W-1:0] CMAP_GRAY  = 2'd0;
  localparam logic [CMAP_W-1:0] CMAP_JET   = 2'd1;
  localparam logic [CMAP_W-1:0] CMAP_HOT   = 2'd2;
  localparam logic [CMAP_W-1:0] CMAP_SPARE = 2'd3;

  localparam logic [CFG_W-1:0]   WIN_LOW_RST  = 18'd0;
  localparam logic [CFG_W-1:0]   WIN_HIGH_RST = 18'd65535;

  typedef struct packed {
    logic signed [NUM_W-1:0] lo;
    logic [DEN_W-1:0]        den;
    logic [GAMMA_W-1:0]      gamma;
    logic                    gamma_on;
    logic                    invert;
    logic [CMAP_W-1:0]       cmap;
  } ptmc_cfg_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  // one slot of the gamma pipeline; each phase uses part of it
  typedef struct packed {
    logic                  v;
    logic [T_W-1:0]        t;
    logic [T_W-1:0]        x;
    logic                  cand_ok;
    logic [LOG_INT_W-1:0]  e;
    logic [MANT_W-1:0]     m;
    logic [LOG_FRAC_W-1:0] frac;
    logic [DT_W-1:0]       w;
    logic [GAMMA_W-1:0]    rem;
    logic [T_W-1:0]        z;
  } gam_st_t;

  function automatic logic [LOG_INT_W-1:0] lead_one(input logic [T_W-1:0] x);
    logic [LOG_INT_W-1:0] e;
    e = '0;
    for (int i = 0; i < T_W; i++) begin
      if (x[i]) begin
        e = LOG_INT_W'(i);
      end
    end
    return e;
  endfunction

  function automatic logic [MANT_W-1:0] log_seed(input logic [T_W-1:0] x,
                                                 input logic [LOG_INT_W-1:0] e);
    logic [MANT_W-1:0] xm;
    logic [5:0]        sh;
    xm = MANT_W'(x);
    sh = 6'(MANT_TOP) - 6'(e);
    return xm << sh;
  endfunction

  // one squaring step: {fraction bit, next mantissa}
  function automatic logic [MANT_W:0] log_square(input logic [MANT_W-1:0] m);
    logic [2*MANT_W-1:0] sq;
    logic [MANT_W-1:0]   m2;
    sq = (2*MANT_W)'(m) * (2*MANT_W)'(m);
    m2 = sq[MANT_TOP+MANT_W-1:MANT_TOP];
    if (m2[MANT_W-1]) begin
      return {1'b1, 1'b0, m2[MANT_W-1:1]};
    end
    return {1'b0, m2};
  endfunction

endpackage

// ----- rtl/ptmc_if.sv -----
interface ptmc_pix_if import ptmc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink (input valid, input pixel_value, output ready);
endinterface

interface ptmc_rgb_if import ptmc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

// ----- rtl/pixel_tone_map_colormap.sv -----
// Throughput: one pixel per clock while the skid slot is empty; every stage is a
// register, with 16 squaring multipliers per log2 evaluation (14 evaluations in
// line).
// Reset (rst, synchronous, active high): all pipeline valid bits and the
// output and skid registers clear; registers return to their defaults.
module pixel_tone_map_colormap import ptmc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  ptmc_pix_if.sink             pixel,
  ptmc_rgb_if.source           color
);

  // Configuration registers, in register-index order.
  logic [CFG_W-1:0]   win_low;
  logic [CFG_W-1:0]   win_high;
  logic [GAMMA_W-1:0] gamma_q8;
  logic               invert_enable;
  logic [CMAP_W-1:0]  colormap_select;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_low         <= WIN_LOW_RST;
      win_high        <= WIN_HIGH_RST;
      gamma_q8        <= GAMMA_UNITY;
      invert_enable   <= 1'b0;
      colormap_select <= CMAP_GRAY;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_WIN_LOW:  win_low         <= cfg_data;
        CFG_WIN_HIGH: win_high        <= cfg_data;
        CFG_GAMMA:    gamma_q8        <= cfg_data[GAMMA_W-1:0];
        CFG_INVERT:   invert_enable   <= cfg_data[0];
        CFG_CMAP:     colormap_select <= cfg_data[CMAP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Derived window/gamma settings, taken straight from the registers so a
  // pixel accepted right after a write already uses the new values.
  // An empty window (high <= low) behaves as a span of one code.
  logic signed [NUM_W-1:0] low_x, high_x, span;
  ptmc_cfg_t               cfg;

  always_comb begin
    low_x  = $signed({win_low[CFG_W-1], win_low});
    high_x = $signed({win_high[CFG_W-1], win_high});
    span   = high_x - low_x;
    cfg.lo       = low_x;
    cfg.den      = (span[NUM_W-1] || (span == '0)) ? DEN_W'(1) : span[DEN_W-1:0];
    cfg.gamma    = gamma_q8;
    cfg.gamma_on = (gamma_q8 != '0) && (gamma_q8 != GAMMA_UNITY);
    cfg.invert   = invert_enable;
    cfg.cmap     = colormap_select;
  end

  // Whole pipeline moves on one enable. It only stops when the skid slot
  // holds a result, so the input side never waits on the output handshake
  // directly, and nothing in flight is lost or doubled.
  logic skid_v;
  logic en;

  assign en          = !skid_v;
  assign pixel.ready = en && !rst;

  // Stage 1: window normalization (subtract, classify, 12-step divide).
  logic           nrm_v;
  logic [T_W-1:0] nrm_t;

  ptmc_norm u_norm (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .cfg    (cfg),
    .in_v   (pixel.valid && pixel.ready),
    .in_pix (pixel.pixel_value),
    .out_v  (nrm_v),
    .out_t  (nrm_t)
  );

  // Stage 2: gamma through log2, divide by gamma, bitwise inverse search.
  // Always traversed; bypassed at its output when gamma is off.
  logic           gam_v;
  logic [T_W-1:0] gam_t;

  ptmc_gamma u_gamma (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .cfg   (cfg),
    .in_v  (nrm_v),
    .in_t  (nrm_t),
    .out_v (gam_v),
    .out_t (gam_t)
  );

  // Stage 3: inversion and colormap.
  logic cm_v;
  rgb_t cm_rgb;

  ptmc_cmap u_cmap (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .cfg     (cfg),
    .in_v    (gam_v),
    .in_t    (gam_t),
    .out_v   (cm_v),
    .out_rgb (cm_rgb)
  );

  // Output register plus one skid slot.
  logic out_v;
  rgb_t out_rgb;
  rgb_t skid_rgb;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (!out_v || color.ready) begin
      if (skid_v) begin
        out_v   <= 1'b1;
        out_rgb <= skid_rgb;
        skid_v  <= 1'b0;
      end else if (en && cm_v) begin
        out_v   <= 1'b1;
        out_rgb <= cm_rgb;
      end else begin
        out_v <= 1'b0;
      end
    end else if (en && cm_v) begin
      // output is held: park the result leaving the pipeline
      skid_v   <= 1'b1;
      skid_rgb <= cm_rgb;
    end
  end

  assign color.valid = out_v;
  assign color.red   = out_rgb.red;
  assign color.green = out_rgb.green;
  assign color.blue  = out_rgb.blue;

endmodule

// ----- rtl/ptmc_norm.sv -----
module ptmc_norm import ptmc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  ptmc_cfg_t        cfg,
  input  logic             in_v,
  input  logic [PIX_W-1:0] in_pix,
  output logic             out_v,
  output logic [T_W-1:0]   out_t
);

  typedef struct packed {
    logic                    v;
    logic signed [NUM_W-1:0] num;
  } nrm_in_t;

  typedef struct packed {
    logic                      v;
    logic                      zero;
    logic                      full;
    logic [DEN_W-1:0]          rem;
    logic [NORM_FRAC_BITS-1:0] q;
  } nrm_div_t;

  nrm_in_t  s0, s0_next;
  nrm_div_t dv [0:NORM_FRAC_BITS];
  nrm_div_t dv0_next;

  logic [PIXEL_BITS-1:0] pix_m;

  always_comb begin
    pix_m = in_pix[PIXEL_BITS-1:0];
    s0_next.v   = in_v;
    s0_next.num = $signed({{(NUM_W-PIXEL_BITS){1'b0}}, pix_m}) - cfg.lo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0.v <= 1'b0;
    end else if (en) begin
      s0 <= s0_next;
    end
  end

  // classify, then seed the long division (num < den inside the window)
  always_comb begin
    dv0_next.v    = s0.v;
    dv0_next.zero = s0.num[NUM_W-1] || (s0.num == '0);
    dv0_next.full = $signed(s0.num) >= $signed({1'b0, cfg.den});
    dv0_next.rem  = s0.num[DEN_W-1:0];
    dv0_next.q    = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0].v <= 1'b0;
    end else if (en) begin
      dv[0] <= dv0_next;
    end
  end

  for (genvar k = 0; k < NORM_FRAC_BITS; k++) begin : g_div
    nrm_div_t       nx;
    logic [DEN_W:0] r2;
    logic           take;

    always_comb begin
      nx   = dv[k];
      r2   = {dv[k].rem, 1'b0};
      take = r2 >= {1'b0, cfg.den};
      nx.rem = take ? DEN_W'(r2 - {1'b0, cfg.den}) : r2[DEN_W-1:0];
      nx.q   = {dv[k].q[NORM_FRAC_BITS-2:0], take};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1].v <= 1'b0;
      end else if (en) begin
        dv[k+1] <= nx;
      end
    end
  end

  assign out_v = dv[NORM_FRAC_BITS].v;
  assign out_t = dv[NORM_FRAC_BITS].zero ? '0 :
                 dv[NORM_FRAC_BITS].full ? ONE_T :
                 {1'b0, dv[NORM_FRAC_BITS].q};

endmodule

// ----- rtl/ptmc_log2.sv -----
module ptmc_log2 import ptmc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    en,
  input  gam_st_t d_in,
  output gam_st_t d_out
);

  gam_st_t st [0:LOG_FRAC_W];
  gam_st_t seed;

  // leading one gives the integer part; mantissa normalized to [2^30, 2^31)
  always_comb begin
    seed      = d_in;
    seed.e    = lead_one(d_in.x);
    seed.m    = log_seed(d_in.x, seed.e);
    seed.frac = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st[0].v <= 1'b0;
    end else if (en) begin
      st[0] <= seed;
    end
  end

  for (genvar i = 0; i < LOG_FRAC_W; i++) begin : g_sq
    gam_st_t         nx;
    logic [MANT_W:0] sqr;

    always_comb begin
      nx      = st[i];
      sqr     = log_square(st[i].m);
      nx.m    = sqr[MANT_W-1:0];
      nx.frac = {st[i].frac[LOG_FRAC_W-2:0], sqr[MANT_W]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st[i+1].v <= 1'b0;
      end else if (en) begin
        st[i+1] <= nx;
      end
    end
  end

  assign d_out = st[LOG_FRAC_W];

endmodule

// ----- rtl/ptmc_gamma.sv -----
module ptmc_gamma import ptmc_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  ptmc_cfg_t      cfg,
  input  logic           in_v,
  input  logic [T_W-1:0] in_t,
  output logic           out_v,
  output logic [T_W-1:0] out_t
);

  gam_st_t gi, gi_next;
  gam_st_t lt_in, lt_out;
  gam_st_t dv [0:DT_W];
  gam_st_t ds_next;
  gam_st_t sr [0:T_W-1];
  gam_st_t last;
  logic [LOG_W-1:0] dist0;

  always_comb begin
    gi_next   = '0;
    gi_next.v = in_v;
    gi_next.t = in_t;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gi.v <= 1'b0;
    end else if (en) begin
      gi <= gi_next;
    end
  end

  // log2 of the intensity; zero is replaced by one and dropped at the end
  always_comb begin
    lt_in   = gi;
    lt_in.x = (gi.t == '0) ? T_W'(1) : gi.t;
  end

  ptmc_log2 u_log_t (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .d_in  (lt_in),
    .d_out (lt_out)
  );

  always_comb begin
    dist0      = LOG_TOP - {lt_out.e, lt_out.frac};
    ds_next     = lt_out;
    ds_next.w   = {dist0, {GAMMA_SHIFT{1'b0}}};
    ds_next.rem = '0;
    ds_next.z   = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0].v <= 1'b0;
    end else if (en) begin
      dv[0] <= ds_next;
    end
  end

  // restoring divide by gamma, one quotient bit per stage; w ends as the target
  for (genvar k = 0; k < DT_W; k++) begin : g_div
    gam_st_t          nx;
    logic [GAMMA_W:0] r2;
    logic             take;

    always_comb begin
      nx   = dv[k];
      r2   = {dv[k].rem, dv[k].w[DT_W-1]};
      take = r2 >= {1'b0, cfg.gamma};
      nx.rem = take ? GAMMA_W'(r2 - {1'b0, cfg.gamma}) : r2[GAMMA_W-1:0];
      nx.w   = {dv[k].w[DT_W-2:0], take};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1].v <= 1'b0;
      end else if (en) begin
        dv[k+1] <= nx;
      end
    end
  end

  // bitwise search for the largest z whose distance still reaches the target
  for (genvar k = 0; k < T_W; k++) begin : g_srch
    localparam int BIT = T_W - 1 - k;

    gam_st_t          prev, pin, lo_k, dn;
    logic [T_W-1:0]   cand;
    logic [LOG_W-1:0] z_dist;

    if (k == 0) begin : g_first
      assign prev = dv[DT_W];
    end else begin : g_rest
      assign prev = sr[k-1];
    end

    always_comb begin
      cand        = prev.z | (T_W'(1) << BIT);
      pin         = prev;
      pin.x       = cand;
      pin.cand_ok = cand <= ONE_T;
    end

    ptmc_log2 u_log_z (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .d_in  (pin),
      .d_out (lo_k)
    );

    always_comb begin
      z_dist = LOG_TOP - {lo_k.e, lo_k.frac};
      dn     = lo_k;
      if (lo_k.cand_ok && ({{GAMMA_SHIFT{1'b0}}, z_dist} >= lo_k.w)) begin
        dn.z = lo_k.x;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sr[k].v <= 1'b0;
      end else if (en) begin
        sr[k] <= dn;
      end
    end
  end

  assign last  = sr[T_W-1];
  assign out_v = last.v;
  assign out_t = !cfg.gamma_on    ? last.t :
                 (last.t == '0)   ? '0     :
                 last.z;

endmodule

// ----- rtl/ptmc_cmap.sv -----
module ptmc_cmap import ptmc_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  ptmc_cfg_t      cfg,
  input  logic           in_v,
  input  logic [T_W-1:0] in_t,
  output logic           out_v,
  output rgb_t           out_rgb
);

  localparam int CV_W = T_W + 3;
  localparam logic signed [CV_W-1:0] JET_PEAK = CV_W'(3 * (1 << NORM_FRAC_BITS) / 2);
  localparam logic signed [CV_W-1:0] ONE_V    = CV_W'(1 << NORM_FRAC_BITS);
  localparam logic [T_W+CH_W-1:0]    HALF     = (T_W+CH_W)'(1 << (NORM_FRAC_BITS - 1));

  typedef struct packed {
    logic                   v;
    logic signed [CV_W-1:0] r;
    logic signed [CV_W-1:0] g;
    logic signed [CV_W-1:0] b;
  } cm_ch_t;

  function automatic logic signed [CV_W-1:0] jet_ch(input logic [T_W-1:0] t,
                                                    input logic [1:0] k);
    logic signed [CV_W-1:0] d;
    d = $signed({1'b0, t, 2'b00}) - $signed(CV_W'(k) << NORM_FRAC_BITS);
    if (d < 0) begin
      d = -d;
    end
    return JET_PEAK - d;
  endfunction

  function automatic logic signed [CV_W-1:0] hot_ch(input logic [T_W-1:0] t,
                                                    input logic [1:0] k);
    logic signed [CV_W-1:0] t3;
    t3 = $signed({2'b00, t, 1'b0}) + $signed({3'b000, t});
    return t3 - $signed(CV_W'(k) << NORM_FRAC_BITS);
  endfunction

  // clamp to [0, 1] and scale to 8 bits, round half up
  function automatic logic [CH_W-1:0] to8(input logic signed [CV_W-1:0] v);
    logic [T_W-1:0]      c;
    logic [T_W+CH_W-1:0] p;
    if (v < 0) begin
      c = '0;
    end else if (v > ONE_V) begin
      c = ONE_T;
    end else begin
      c = v[T_W-1:0];
    end
    p = {c, {CH_W{1'b0}}} - (T_W+CH_W)'(c) + HALF;
    return p[NORM_FRAC_BITS+CH_W-1:NORM_FRAC_BITS];
  endfunction

  logic           c0_v;
  logic [T_W-1:0] c0_t;
  cm_ch_t         c1, c1_next;
  logic           c2_v;
  rgb_t           c2_rgb;

  always_ff @(posedge clk) begin
    if (rst) begin
      c0_v <= 1'b0;
    end else if (en) begin
      c0_v <= in_v;
      c0_t <= cfg.invert ? ONE_T - in_t : in_t;
    end
  end

  always_comb begin
    c1_next.v = c0_v;
    case (cfg.cmap)
      CMAP_JET: begin
        c1_next.r = jet_ch(c0_t, 2'd3);
        c1_next.g = jet_ch(c0_t, 2'd2);
        c1_next.b = jet_ch(c0_t, 2'd1);
      end
      CMAP_HOT: begin
        c1_next.r = hot_ch(c0_t, 2'd0);
        c1_next.g = hot_ch(c0_t, 2'd1);
        c1_next.b = hot_ch(c0_t, 2'd2);
      end
      default: begin
        c1_next.r = $signed({3'b000, c0_t});
        c1_next.g = $signed({3'b000, c0_t});
        c1_next.b = $signed({3'b000, c0_t});
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1.v <= 1'b0;
    end else if (en) begin
      c1 <= c1_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c2_v <= 1'b0;
    end else if (en) begin
      c2_v         <= c1.v;
      c2_rgb.red   <= to8(c1.r);
      c2_rgb.green <= to8(c1.g);
      c2_rgb.blue  <= to8(c1.b);
    end
  end

  assign out_v   = c2_v;
  assign out_rgb = c2_rgb;

endmodule

// ----- rtl/ptmc_checker.sv -----
`include "pixel_tone_map_colormap_assert.svh"

module ptmc_checker import ptmc_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 cfg_write,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [CFG_W-1:0]     cfg_data,
  input logic                 pixel_ready,
  input logic                 color_valid,
  input logic                 color_ready,
  input logic [CH_W-1:0]      red,
  input logic [CH_W-1:0]      green,
  input logic [CH_W-1:0]      blue
);

  // colormap as seen on the write port
  logic [CMAP_W-1:0] cmap_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmap_seen <= CMAP_GRAY;
    end else if (cfg_write && (cfg_index == CFG_CMAP)) begin
      cmap_seen <= cfg_data[CMAP_W-1:0];
    end
  end

  `PTMC_ASSERT_NEXT(a_hold_valid, color_valid && !color_ready, color_valid, "result dropped while stalled")
  `PTMC_ASSERT_NEXT(a_hold_data, color_valid && !color_ready, $stable(red) && $stable(green) && $stable(blue), "result changed while stalled")
  `PTMC_ASSERT_NEXT(a_ready_back, color_ready, pixel_ready, "input still blocked after output drained")
  `PTMC_ASSERT_NOW(a_gray_equal, color_valid && (cmap_seen != CMAP_JET) && (cmap_seen != CMAP_HOT), (red == green) && (green == blue), "gray channels differ")
  `PTMC_ASSERT_NOW(a_hot_order, color_valid && (cmap_seen == CMAP_HOT), (red >= green) && (green >= blue), "hot channels out of order")

endmodule

bind pixel_tone_map_colormap ptmc_checker u_ptmc_checker (
  .clk         (clk),
  .rst         (rst),
  .cfg_write   (cfg_write),
  .cfg_index   (cfg_index),
  .cfg_data    (cfg_data),
  .pixel_ready (pixel.ready),
  .color_valid (color.valid),
  .color_ready (color.ready),
  .red         (color.red),
  .green       (color.green),
  .blue        (color.blue)
);

// ----- verif/tb_pixel_tone_map_colormap.sv -----
`timescale 1ns / 100ps

module tb_pixel_tone_map_colormap;
  import ptmc_pkg::*;

  // Pipeline depth of the block; used for the final drain.
  localparam int PIPE_LAT    = 299;
  localparam int PHASE_ITEMS = 75;
  localparam int NUM_PHASES  = 12;

  typedef struct {
    logic [PIX_W-1:0] pix;
    bit               known;  // expected color typed in, valid under reset setup only
    rgb_t             rgb;
  } pix_row_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  ptmc_pix_if pix_bus ();
  ptmc_rgb_if rgb_bus ();

  pixel_tone_map_colormap i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixel     (pix_bus),
    .color     (rgb_bus)
  );

  // Shadow copy of the register file, updated once each setup load completes.
  logic signed [CFG_W-1:0] sh_low;
  logic signed [CFG_W-1:0] sh_high;
  logic [GAMMA_W-1:0]      sh_gamma;
  logic                    sh_invert;
  logic [CMAP_W-1:0]       sh_cmap;

  rgb_t color_q[$];   // colors still owed by the pipeline
  int   err_cnt = 0;
  int   rx_cycle;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Color predictor
  // ---------------------------------------------------------------------------

  // log2 with 16 fraction bits: integer part from the leading one, fraction by
  // repeated squaring of a Q30 mantissa with truncation.
  function automatic longint unsigned log2_q16(input longint unsigned x);
    longint unsigned m;
    longint unsigned frac;
    int e;
    e = 0;
    frac = 0;
    while (e < 16 && (x >> (e + 1)) != 0) e++;
    m = x << (30 - e);
    for (int i = 15; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac |= (64'd1 << i);
      end
    end
    return (longint'(e) << 16) | frac;
  endfunction

  function automatic longint unsigned log_dist(input longint z);
    return (longint'(NORM_FRAC_BITS) << 16) - log2_q16(z);
  endfunction

  // t^(1/gamma): largest z whose log distance still covers the scaled one.
  function automatic longint gamma_curve(input longint t, input longint g);
    longint unsigned dt;
    longint lo, hi, mid;
    lo = 0;
    hi = longint'(ONE_T);
    if (t <= 0) return 0;
    dt = log_dist(t) * 256 / g;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (log_dist(mid) >= dt) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic logic [CH_W-1:0] chan8(input longint v);
    longint one;
    one = longint'(ONE_T);
    if (v < 0) v = 0;
    if (v > one) v = one;
    return CH_W'((v * 255 + one / 2) >> NORM_FRAC_BITS);
  endfunction

  function automatic longint jet_arm(input longint t, input longint k);
    longint d;
    d = 4 * t - k * longint'(ONE_T);
    if (d < 0) d = -d;
    return (3 * longint'(ONE_T)) / 2 - d;
  endfunction

  function automatic rgb_t map_color(input logic [PIX_W-1:0] pix);
    longint lo, hi, num, den, t, one;
    rgb_t c;
    one = longint'(ONE_T);
    lo = longint'(sh_low);
    hi = longint'(sh_high);
    if (hi <= lo) hi = lo + 1;  // empty window
    num = longint'({1'b0, pix}) - lo;
    den = hi - lo;
    if (num <= 0) t = 0;
    else if (num >= den) t = one;
    else t = (num << NORM_FRAC_BITS) / den;
    if (sh_gamma != '0 && sh_gamma != GAMMA_UNITY) t = gamma_curve(t, longint'(sh_gamma));
    if (sh_invert) t = one - t;
    case (sh_cmap)
      CMAP_JET: begin
        c.red   = chan8(jet_arm(t, 3));
        c.green = chan8(jet_arm(t, 2));
        c.blue  = chan8(jet_arm(t, 1));
      end
      CMAP_HOT: begin
        c.red   = chan8(3 * t);
        c.green = chan8(3 * t - one);
        c.blue  = chan8(3 * t - 2 * one);
      end
      default: begin  // gray, spare code acts as gray
        c.red   = chan8(t);
        c.green = c.red;
        c.blue  = c.red;
      end
    endcase
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver side
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: %s mismatch: got %0d, want %0d", $realtime, what, got, want);
    err_cnt++;
  endtask

  // Writes the full register set in back-to-back cycles; pipeline must be empty.
  task automatic load_setup(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi,
                            input logic [GAMMA_W-1:0] g, input logic inv,
                            input logic [CMAP_W-1:0] cm);
    logic [CFG_W-1:0] vals[5];
    logic [CFG_IDX_W-1:0] idx[5];
    vals = '{lo, hi, CFG_W'(g), CFG_W'(inv), CFG_W'(cm)};
    idx  = '{CFG_WIN_LOW, CFG_WIN_HIGH, CFG_GAMMA, CFG_INVERT, CFG_CMAP};
    for (int i = 0; i < 5; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    sh_low    = lo;
    sh_high   = hi;
    sh_gamma  = g;
    sh_invert = inv;
    sh_cmap   = cm;
  endtask

  // Holds one pixel request until it is taken, queueing its expected color.
  task automatic send_pixel(input logic [PIX_W-1:0] pix, input bit known, input rgb_t rgb);
    pix_bus.valid       <= 1'b1;
    pix_bus.pixel_value <= pix;
    do @(posedge clk); while (!pix_bus.ready);
    color_q.push_back(known ? rgb : map_color(pix));
  endtask

  task automatic idle_cycles(input int n);
    pix_bus.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain_pipe();
    pix_bus.valid <= 1'b0;
    while (color_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Pixel biased toward the window edges half the time.
  function automatic logic [PIX_W-1:0] pick_pixel();
    longint p;
    case ($urandom_range(0, 3))
      0: p = longint'(sh_low) + $urandom_range(0, 8) - 4;
      1: p = longint'(sh_high) + $urandom_range(0, 8) - 4;
      default: return PIX_W'($urandom);
    endcase
    if (p < 0) p = 0;
    if (p > 65535) p = 65535;
    return PIX_W'(p);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  pix_row_t dir_rows[10];

  initial begin
    int burst;
    rgb_t none;
    logic [CFG_W-1:0] lo, hi;
    logic [GAMMA_W-1:0] g;

    none = '0;
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    pix_bus.valid <= 1'b0;
    pix_bus.pixel_value <= '0;
    sh_low    = WIN_LOW_RST;
    sh_high   = WIN_HIGH_RST;
    sh_gamma  = GAMMA_UNITY;
    sh_invert = 1'b0;
    sh_cmap   = CMAP_GRAY;

    // Reset setup: full 16-bit window, no gamma, gray.
    dir_rows = '{
      '{16'h0000, 1'b1, '{8'd0,   8'd0,   8'd0}},
      '{16'hFFFF, 1'b1, '{8'd255, 8'd255, 8'd255}},
      '{16'h8000, 1'b1, '{8'd128, 8'd128, 8'd128}},
      '{16'h0001, 1'b0, none},
      '{16'hFFFE, 1'b0, none},
      '{16'h5555, 1'b0, none},
      '{16'hAAAA, 1'b0, none},
      '{16'h00FF, 1'b0, none},
      '{16'hFF00, 1'b0, none},
      '{16'h0FFF, 1'b0, none}
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows, back to back, under the reset setup.
    foreach (dir_rows[i]) send_pixel(dir_rows[i].pix, dir_rows[i].known, dir_rows[i].rgb);
    drain_pipe();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // Fixed corner setups first, then random ones.
      case (ph)
        0: load_setup(18'd0, 18'd65535, 12'd128, 1'b0, CMAP_JET);
        1: load_setup(18'd1000, 18'd1000, 12'd0, 1'b1, CMAP_HOT);            // empty window
        2: load_setup(18'h20000, 18'h1FFFF, 12'd4095, 1'b0, CMAP_SPARE);     // widest window
        3: load_setup(18'h1FFFF, 18'h20000, 12'd1, 1'b1, CMAP_GRAY);         // reversed, tiny gamma
        4: load_setup(18'd20000, 18'd40000, 12'd300, 1'b0, CMAP_JET);
        5: load_setup(18'd60000, 18'd60100, 12'd700, 1'b1, CMAP_HOT);
        default: begin
          lo = $urandom_range(0, 1) ? CFG_W'($urandom) : CFG_W'($urandom_range(0, 60000));
          hi = $urandom_range(0, 3) == 0 ? CFG_W'($urandom)
                                         : lo + CFG_W'($urandom_range(1, 20000));
          case ($urandom_range(0, 3))
            0: g = $urandom_range(0, 1) ? 12'd0 : GAMMA_UNITY;
            1: g = GAMMA_W'($urandom_range(1, 255));
            default: g = GAMMA_W'($urandom_range(257, 4095));
          endcase
          load_setup(lo, hi, g, 1'($urandom), CMAP_W'($urandom));
        end
      endcase

      // Bursts of requests with random gaps; some phases run without gaps.
      burst = 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (burst == 0) begin
          burst = $urandom_range(1, 24);
          if (ph % 4 != 2) idle_cycles($urandom_range(1, 8));
        end
        send_pixel(pick_pixel(), 1'b0, none);
        burst--;
      end
      // Sender holds off until every color is back before the next setup.
      drain_pipe();
    end

    repeat (PIPE_LAT + 20) @(posedge clk);
    if (err_cnt == 0 && color_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern and color check
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    rgb_t want;
    if (rst) begin
      rx_cycle <= 0;
      rgb_bus.ready <= 1'b0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (rgb_bus.valid && rgb_bus.ready) begin
        if (color_q.size() == 0) begin
          report_mismatch("pending requests", 0, 1);
        end else begin
          want = color_q.pop_front();
          if (rgb_bus.red !== want.red) report_mismatch("red", rgb_bus.red, want.red);
          if (rgb_bus.green !== want.green) report_mismatch("green", rgb_bus.green, want.green);
          if (rgb_bus.blue !== want.blue) report_mismatch("blue", rgb_bus.blue, want.blue);
        end
      end
      // Modes rotate with the cycle counter: always ready, random, periodic stall.
      case ((rx_cycle >> 8) % 3)
        0: rgb_bus.ready <= 1'b1;
        1: rgb_bus.ready <= ($urandom_range(0, 9) < 7);
        default: rgb_bus.ready <= (rx_cycle % 7) > 2;
      endcase
    end
  end

endmodule
